// ===== design/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and alphabet functions of the streaming base64 codec.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // Queue between the front and the back part.
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Result status codes.
   localparam logic [1:0] ST_DATA     = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_BAD_PAD  = 2'd2;
   localparam logic [1:0] ST_SHORT    = 2'd3;

   // Job kinds held in the queue.
   localparam logic [1:0] KIND_ENC = 2'd0;
   localparam logic [1:0] KIND_DEC = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_C62  = 2'd1;
   localparam logic [1:0] REG_C63  = 2'd2;
   localparam logic [1:0] REG_PAD  = 2'd3;

   // Reset values of the registers.
   localparam logic [7:0] RESET_C62 = 8'd43;
   localparam logic [7:0] RESET_C63 = 8'd45;
   localparam logic [7:0] RESET_PAD = 8'd61;

   // Mode values.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Alphabet anchors.
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHR_DIGIT_9 = 8'h39;

   typedef struct packed {
      logic [7:0] data_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [1:0] status;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_for_62;
      logic [7:0] char_for_63;
      logic [7:0] pad_char;
   } cfg_type;

   // One group's worth of work for the back part.
   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] bits;
      logic [1:0]  count;
      logic [1:0]  status;
   } job_type;

   typedef struct packed {
      logic                     full;
      logic                     empty;
      logic [QueueCntWidth-1:0] count;
   } q_status_type;

   // Character for a sextet value.
   function automatic logic [7:0] sextet_char(input logic [5:0] s,
                                              input logic [7:0] c62,
                                              input logic [7:0] c63);
      logic [7:0] s8;
      s8 = {2'b00, s};
      if (s8 < 8'd26) begin
         sextet_char = CHR_UPPER_A + s8;
      end else if (s8 < 8'd52) begin
         sextet_char = CHR_LOWER_A + s8 - 8'd26;
      end else if (s8 < 8'd62) begin
         sextet_char = CHR_DIGIT_0 + s8 - 8'd52;
      end else if (s8 == 8'd62) begin
         sextet_char = c62;
      end else begin
         sextet_char = c63;
      end
   endfunction

   // Sextet value of a character; bit 6 set marks a character outside the alphabet.
   function automatic logic [6:0] char_sextet(input logic [7:0] c,
                                              input logic [7:0] c62,
                                              input logic [7:0] c63);
      logic [7:0] v;
      v = 8'd64;
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
         v = c - CHR_UPPER_A;
      end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
         v = c - CHR_LOWER_A + 8'd26;
      end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
         v = c - CHR_DIGIT_0 + 8'd52;
      end else if (c == c62) begin
         v = 8'd62;
      end else if (c == c63) begin
         v = 8'd63;
      end
      char_sextet = v[6:0];
   endfunction

endpackage

// ===== design/bsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_front
// Accepts input words, gathers groups and queues one job per finished group.
// ----------------------------------------------------------------------------
module bsc_front (
   input  logic              clock,
   input  logic              reset,
   input  bsc_pkg::cfg_type  cfg,
   input  logic              mode_clear,
   input  logic              req_valid,
   input  bsc_pkg::req_type  req,
   output logic              req_stall,
   input  logic              q_full,
   output logic              push,
   output bsc_pkg::job_type  job
);
   import bsc_pkg::*;

   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [2:0]  pads_seen_ff, pads_seen_in;
   logic        bad_char_ff, bad_char_in;
   logic        pad_misplaced_ff, pad_misplaced_in;

   logic        accept;
   logic [2:0]  cnt;
   logic        is_pad;
   logic [6:0]  sx;
   logic [5:0]  sextet;
   logic [2:0]  pads_next;
   logic        bad_next;
   logic        mis_next;
   logic        make_job;
   logic        clear;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cnt       = {1'b0, group_count_ff} + 3'd1;

   // Classify the incoming character for decode.
   always_comb begin
      is_pad    = (req.data_in == cfg.pad_char);
      sx        = char_sextet(req.data_in, cfg.char_for_62, cfg.char_for_63);
      pads_next = pads_seen_ff;
      bad_next  = bad_char_ff;
      mis_next  = pad_misplaced_ff;
      sextet    = 6'd0;
      if (is_pad) begin
         if (pads_seen_ff < 3'd4) begin
            pads_next = pads_seen_ff + 3'd1;
         end
      end else if (sx[6]) begin
         bad_next = 1'b1;
      end else begin
         sextet = sx[5:0];
         if (pads_seen_ff != 3'd0) begin
            mis_next = 1'b1;
         end
      end
   end

   // Build the job for a finished group and the next group state.
   always_comb begin
      job              = '0;
      make_job         = 1'b0;
      clear            = 1'b0;
      group_bits_in    = group_bits_ff;
      group_count_in   = group_count_ff;
      pads_seen_in     = pads_seen_ff;
      bad_char_in      = bad_char_ff;
      pad_misplaced_in = pad_misplaced_ff;
      if (cfg.mode == MODE_ENCODE) begin
         group_bits_in = {group_bits_ff[15:0], req.data_in};
         if (cnt < 3'd3 && !req.end_of_input) begin
            group_count_in = cnt[1:0];
         end else begin
            make_job  = 1'b1;
            clear     = 1'b1;
            job.kind  = KIND_ENC;
            job.count = cnt[1:0];
            case (cnt)
               3'd1:    job.bits = {req.data_in, 16'h0000};
               3'd2:    job.bits = {group_bits_ff[7:0], req.data_in, 8'h00};
               default: job.bits = {group_bits_ff[15:0], req.data_in};
            endcase
         end
      end else begin
         group_bits_in    = {group_bits_ff[17:0], sextet};
         pads_seen_in     = pads_next;
         bad_char_in      = bad_next;
         pad_misplaced_in = mis_next;
         if (cnt < 3'd4) begin
            if (req.end_of_input) begin
               make_job   = 1'b1;
               clear      = 1'b1;
               job.kind   = KIND_ERR;
               job.status = ST_SHORT;
            end else begin
               group_count_in = cnt[1:0];
            end
         end else begin
            make_job = 1'b1;
            clear    = 1'b1;
            if (bad_next) begin
               job.kind   = KIND_ERR;
               job.status = ST_BAD_CHAR;
            end else if (pads_next > 3'd2 || mis_next) begin
               job.kind   = KIND_ERR;
               job.status = ST_BAD_PAD;
            end else begin
               job.kind  = KIND_DEC;
               job.bits  = group_bits_in;
               job.count = 2'd3 - pads_next[1:0];
            end
         end
      end
   end

   assign push = accept && make_job;

   // Group state registers; reset, a mode write or a finished group clears them.
   always_ff @(posedge clock) begin
      if (reset || mode_clear || (accept && clear)) begin
         group_bits_ff    <= '0;
         group_count_ff   <= '0;
         pads_seen_ff     <= '0;
         bad_char_ff      <= 1'b0;
         pad_misplaced_ff <= 1'b0;
      end else if (accept) begin
         group_bits_ff    <= group_bits_in;
         group_count_ff   <= group_count_in;
         pads_seen_ff     <= pads_seen_in;
         bad_char_ff      <= bad_char_in;
         pad_misplaced_ff <= pad_misplaced_in;
      end
   end

endmodule

// ===== design/bsc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_queue
// Short job queue that lets the front and the back part stall on their own.
// ----------------------------------------------------------------------------
module bsc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bsc_pkg::job_type      push_job,
   input  logic                  pop,
   output bsc_pkg::job_type      head,
   output bsc_pkg::q_status_type status
);
   import bsc_pkg::*;

   job_type                  entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntWidth-1:0] count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QueueCntWidth'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   // Storage needs no reset; only the pointers and the count do.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 :
                         wr_ptr_ff + QueuePtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 :
                         rd_ptr_ff + QueuePtrWidth'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QueueCntWidth'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QueueCntWidth'(1);
         end
      end
   end

endmodule

// ===== design/bsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_back
// Expands the job at the queue head into result words, one word per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module bsc_back (
   input  logic             clock,
   input  logic             reset,
   input  bsc_pkg::cfg_type cfg,
   input  bsc_pkg::job_type head,
   input  logic             q_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsc_pkg::rsp_type rsp
);
   import bsc_pkg::*;

   logic [1:0] word_idx_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic [5:0] sextet;
   logic       is_pad;

   assign load = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && rsp_in.last_of_run;

   // Pick the word of the current job that comes next.
   always_comb begin
      case (word_idx_ff)
         2'd0:    sextet = head.bits[23:18];
         2'd1:    sextet = head.bits[17:12];
         2'd2:    sextet = head.bits[11:6];
         default: sextet = head.bits[5:0];
      endcase
      is_pad = (head.count == 2'd1 && word_idx_ff >= 2'd2) ||
               (head.count == 2'd2 && word_idx_ff == 2'd3);
      rsp_in = '0;
      case (head.kind)
         KIND_ENC: begin
            rsp_in.data_out    = is_pad ? cfg.pad_char :
                                 sextet_char(sextet, cfg.char_for_62, cfg.char_for_63);
            rsp_in.status      = ST_DATA;
            rsp_in.last_of_run = (word_idx_ff == 2'd3);
         end
         KIND_DEC: begin
            case (word_idx_ff)
               2'd0:    rsp_in.data_out = head.bits[23:16];
               2'd1:    rsp_in.data_out = head.bits[15:8];
               default: rsp_in.data_out = head.bits[7:0];
            endcase
            rsp_in.status      = ST_DATA;
            rsp_in.last_of_run = (word_idx_ff == head.count - 2'd1);
         end
         default: begin
            rsp_in.data_out    = 8'h00;
            rsp_in.status      = head.status;
            rsp_in.last_of_run = 1'b1;
         end
      endcase
   end

   // Output register and word counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         word_idx_ff  <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         word_idx_ff  <= rsp_in.last_of_run ? 2'd0 : word_idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/base64_stream_codec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming base64 encoder and decoder, one byte or character per word.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  data_in, end_of_input
// rsp       out        rsp_valid / rsp_stall  data_out, status, last_of_run
// csr       in/out     psel, penable, pready  mode, char_for_62/63, pad_char
//
// An input word is taken while the job queue is not full; a finished group goes to a four-deep
// job queue. The back part sends one result word per cycle while rsp_stall is low, so encoding gives
// four characters per group of up to three bytes and decoding up to three bytes per four characters.
// There is no clearing pass: the block takes words from the first cycle
// after reset. req_stall rises only while the job queue is full, and the
// output register frees itself whenever rsp_stall is low.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsc_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsc_pkg::rsp_type rsp,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bsc_pkg::*;

   cfg_type      cfg_ff;
   logic         wr_en;
   logic [1:0]   reg_idx;
   logic         mode_clear;
   logic         q_push;
   logic         q_pop;
   job_type      q_in_job;
   job_type      q_head;
   q_status_type q_status;

   // Register port: always ready, write on the access cycle.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign mode_clear = wr_en && (reg_idx == REG_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_ENCODE;
         cfg_ff.char_for_62 <= RESET_C62;
         cfg_ff.char_for_63 <= RESET_C63;
         cfg_ff.pad_char    <= RESET_PAD;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MODE: cfg_ff.mode        <= csr_pwdata[0];
            REG_C62:  cfg_ff.char_for_62 <= csr_pwdata[7:0];
            REG_C63:  cfg_ff.char_for_63 <= csr_pwdata[7:0];
            REG_PAD:  cfg_ff.pad_char    <= csr_pwdata[7:0];
            default:  cfg_ff.mode        <= cfg_ff.mode;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_idx)
         REG_MODE: csr_prdata = {31'd0, cfg_ff.mode};
         REG_C62:  csr_prdata = {24'd0, cfg_ff.char_for_62};
         REG_C63:  csr_prdata = {24'd0, cfg_ff.char_for_63};
         REG_PAD:  csr_prdata = {24'd0, cfg_ff.pad_char};
         default:  csr_prdata = 32'd0;
      endcase
   end

   bsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mode_clear (mode_clear),
      .req_valid  (req_valid),
      .req        (req),
      .req_stall  (req_stall),
      .q_full     (q_status.full),
      .push       (q_push),
      .job        (q_in_job)
   );

   bsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   bsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .q_empty   (q_status.empty),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // The queue never holds more jobs than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QueueCntWidth'(QueueDepth))
      else $error("job queue count above depth");

   // No job is written into a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   // Error results carry a zero byte and close their run.
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_DATA) |-> (rsp.data_out == 8'h00 && rsp.last_of_run))
      else $error("malformed error result");

   // A job leaves the queue only once its last word is loaded.
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid && rsp.last_of_run)
      else $error("job popped before its last word");
`endif

endmodule
